// File: rtl/assert_macros.svh
// Assertion helpers used by the RTL file mcfg_core.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MCFG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MCFG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/mcfg_pkg.sv
`default_nettype none
package mcfg_pkg;

	localparam int MOTOR_COUNT = 12;
	localparam int GROUP_COUNT = 4;
	localparam int ID_W = 4;
	localparam int VALUE_W = 16;
	localparam int GROUP_W = 2;
	localparam int SLOT_W = 2;
	localparam int PAYLOAD_W = 64;

	localparam logic [3:0] FULL_FOUR = 4'hF;
	localparam logic [3:0] FULL_TWO = 4'h3;

	localparam logic [GROUP_W-1:0] GROUP_FRONT = 2'd0;
	localparam logic [GROUP_W-1:0] GROUP_SIDE_A = 2'd1;
	localparam logic [GROUP_W-1:0] GROUP_REAR = 2'd2;
	localparam logic [GROUP_W-1:0] GROUP_SIDE_B = 2'd3;

	typedef struct packed {
		logic [ID_W-1:0] motor_id;
		logic [VALUE_W-1:0] intensity;
	} mcfg_item_t;

	typedef struct packed {
		logic frame_sent;
		logic [GROUP_W-1:0] frame_group;
		logic [PAYLOAD_W-1:0] frame_payload;
		logic bad_id;
	} mcfg_result_t;

	function automatic logic [GROUP_W-1:0] group_of(input logic [ID_W-1:0] id);
		logic [GROUP_W-1:0] g;
		case (id) inside
			[4'd0:4'd3]: g = GROUP_FRONT;
			[4'd4:4'd5]: g = GROUP_SIDE_A;
			[4'd6:4'd9]: g = GROUP_REAR;
			default: g = GROUP_SIDE_B;
		endcase
		return g;
	endfunction

	function automatic logic [ID_W-1:0] group_base(input logic [GROUP_W-1:0] g);
		logic [ID_W-1:0] b;
		case (g)
			GROUP_FRONT: b = 4'd0;
			GROUP_SIDE_A: b = 4'd4;
			GROUP_REAR: b = 4'd6;
			default: b = 4'd10;
		endcase
		return b;
	endfunction

	function automatic logic [3:0] group_full(input logic [GROUP_W-1:0] g);
		logic [3:0] f;
		case (g)
			GROUP_FRONT, GROUP_REAR: f = FULL_FOUR;
			default: f = FULL_TWO;
		endcase
		return f;
	endfunction

endpackage
`default_nettype wire

// File: rtl/motor_command_frame_gatherer.sv
`default_nettype none
// Gathers signed drive commands for twelve motors in four groups and emits one
// result word per input word, at a sustained rate of one word per clock while
// the output is ready: a word goes through an input register, update and frame
// packing against the per-motor value registers, and an output register.
// Output backpressure stalls the input only once both registers are full. The
// direction mask must be written only while no word is in flight.
module motor_command_frame_gatherer (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [11:0] cfg_data,      // direction_mask
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [15:0] s_axis_tdata,  // intensity
	input wire logic [3:0] s_axis_tuser,   // motor_id
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [63:0] m_axis_tdata,      // frame_payload
	output logic [3:0] m_axis_tuser        // frame_sent, frame_group[1:0], bad_id
);
	import mcfg_pkg::*;

	logic [MOTOR_COUNT-1:0] dir_mask_q;
	mcfg_item_t in_item;
	mcfg_item_t item_s1;
	logic item_valid_s1;
	logic advance;
	mcfg_result_t result;
	mcfg_result_t result_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_mask_q <= '0;
		end else if (cfg_valid) begin
			dir_mask_q <= cfg_data;
		end
	end

	assign in_item.motor_id = s_axis_tuser;
	assign in_item.intensity = s_axis_tdata;

	mcfg_in_stage u_in (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_item(in_item),
		.advance(advance),
		.item_valid_s1(item_valid_s1),
		.item_s1(item_s1)
	);

	mcfg_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.dir_mask(dir_mask_q),
		.fire(item_valid_s1 && advance),
		.item(item_s1),
		.result(result)
	);

	mcfg_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(item_valid_s1),
		.result(result),
		.out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid),
		.advance(advance),
		.result_q(result_q)
	);

	assign m_axis_tdata = result_q.frame_payload;
	assign m_axis_tuser = {result_q.bad_id, result_q.frame_group, result_q.frame_sent};

endmodule
`default_nettype wire

// File: rtl/mcfg_in_stage.sv
`default_nettype none
module mcfg_in_stage (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire mcfg_pkg::mcfg_item_t in_item,
	input wire logic advance,
	output logic item_valid_s1,
	output mcfg_pkg::mcfg_item_t item_s1
);
	import mcfg_pkg::*;

	// A held word leaves whenever the processing stage advances.
	assign in_ready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule
`default_nettype wire

// File: rtl/mcfg_core.sv
`default_nettype none
`include "assert_macros.svh"
module mcfg_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [mcfg_pkg::MOTOR_COUNT-1:0] dir_mask,
	input wire logic fire,
	input wire mcfg_pkg::mcfg_item_t item,
	output mcfg_pkg::mcfg_result_t result
);
	import mcfg_pkg::*;

	logic [VALUE_W-1:0] values_q [MOTOR_COUNT];
	logic [3:0] ready_q [GROUP_COUNT];

	logic id_ok;
	logic [GROUP_W-1:0] grp;
	logic [SLOT_W-1:0] slot;
	logic [3:0] full;
	logic [3:0] rdy_cur;
	logic [3:0] rdy_new;
	logic complete;
	logic [VALUE_W-1:0] v_store;
	logic [VALUE_W-1:0] vals_upd [MOTOR_COUNT];
	logic [PAYLOAD_W-1:0] payload;

	always_comb begin
		id_ok = item.motor_id < ID_W'(MOTOR_COUNT);
		grp = group_of(item.motor_id);
		slot = SLOT_W'(item.motor_id - group_base(grp));
		full = group_full(grp);
		rdy_cur = ready_q[grp];
		// Writing a motor twice before its group is sent forces the frame out.
		rdy_new = rdy_cur[slot] ? full : (rdy_cur | (4'b0001 << slot));
		complete = id_ok && (rdy_new == full);
		v_store = (id_ok && dir_mask[item.motor_id]) ?
			VALUE_W'(16'd0 - item.intensity) : item.intensity;
		for (int i = 0; i < MOTOR_COUNT; i++) begin
			vals_upd[i] = (id_ok && item.motor_id == ID_W'(i)) ? v_store : values_q[i];
		end
		case (grp)
			GROUP_FRONT: payload = {vals_upd[1], vals_upd[0], vals_upd[2], vals_upd[3]};
			GROUP_SIDE_A: payload = {vals_upd[4], vals_upd[5], 32'd0};
			GROUP_REAR: payload = {vals_upd[6], vals_upd[7], vals_upd[8], vals_upd[9]};
			default: payload = {vals_upd[10], vals_upd[11], 32'd0};
		endcase
		result.frame_sent = complete;
		result.frame_group = complete ? grp : '0;
		result.frame_payload = complete ? payload : '0;
		result.bad_id = !id_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				values_q[i] <= '0;
			end
			for (int g = 0; g < GROUP_COUNT; g++) begin
				ready_q[g] <= '0;
			end
		end else if (fire && id_ok) begin
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				if (complete && group_of(ID_W'(i)) == grp) begin
					values_q[i] <= '0;
				end else begin
					values_q[i] <= vals_upd[i];
				end
			end
			ready_q[grp] <= complete ? 4'd0 : rdy_new;
		end
	end

	`MCFG_ASSERT_NOW(a_sent_not_bad, clk, arst_n, result.bad_id, !result.frame_sent)
	`MCFG_ASSERT_NOW(a_group_zero_idle, clk, arst_n, !result.frame_sent,
		result.frame_group == '0 && result.frame_payload == '0)
	`MCFG_ASSERT_NEXT(a_group_cleared, clk, arst_n, fire && result.frame_sent,
		ready_q[$past(result.frame_group)] == 4'd0)

endmodule
`default_nettype wire

// File: rtl/mcfg_out_stage.sv
`default_nettype none
module mcfg_out_stage (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic load,
	input wire mcfg_pkg::mcfg_result_t result,
	input wire logic out_ready,
	output logic out_valid,
	output logic advance,
	output mcfg_pkg::mcfg_result_t result_q
);
	import mcfg_pkg::*;

	// The register can take a new word when empty or when its word leaves now.
	assign advance = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load) begin
			result_q <= result;
		end
	end

endmodule
`default_nettype wire
